>>> src/rc_channel_pulse_packer_macros.svh
// ----------------------------------------------------------------------------
// rc channel pulse packer assertion macros
// shared property wrappers, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef RC_CHANNEL_PULSE_PACKER_MACROS_SVH
`define RC_CHANNEL_PULSE_PACKER_MACROS_SVH

// same-cycle implication
`define RCPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rcpp_pkg.sv
// ----------------------------------------------------------------------------
// rcpp_pkg
// types and constants shared by the rc channel pulse packer modules
// ----------------------------------------------------------------------------
package rcpp_pkg;

  typedef enum logic [1:0] {
    FS_MODE_CUSTOM  = 2'd0,
    FS_MODE_HOLD    = 2'd1,
    FS_MODE_NOPULSE = 2'd2
  } fs_mode_e;

  typedef enum logic [1:0] {
    FS_KIND_VALUE   = 2'd0,
    FS_KIND_HOLD    = 2'd1,
    FS_KIND_NOPULSE = 2'd2
  } fs_kind_e;

  typedef enum logic [1:0] {
    SEL_LO  = 2'd0,
    SEL_MID = 2'd1,
    SEL_HI  = 2'd2
  } byte_sel_e;

  typedef enum logic {
    CFG_FS_MODE    = 1'b0,
    CFG_ACTIVE_CHS = 1'b1
  } cfg_reg_e;

  localparam int unsigned CfgIdxW = 2;

  typedef struct packed {
    logic [2:0]         slot;
    logic               send_failsafe;
    logic [3:0]         upper_count;
    logic signed [11:0] channel_value;
    logic signed [10:0] center_offset;
    logic signed [11:0] failsafe_value;
    logic [1:0]         failsafe_kind;
  } item_t;

  typedef struct packed {
    logic [11:0] held;
    logic [11:0] pulse;
  } pair_t;

  // x*512/682 == x*256/341; exact for |x|*256 < 2^20 with this reciprocal
  localparam logic [20:0] RecipK     = 21'd1574402;
  localparam int unsigned RecipShift = 21;

  localparam logic [11:0] CodeHoldLo    = 12'd2047;
  localparam logic [11:0] CodeHoldHi    = 12'd4095;
  localparam logic [11:0] CodeNoPulseLo = 12'd0;
  localparam logic [11:0] CodeNoPulseHi = 12'd2048;
  localparam logic [11:0] CodeNeutral   = 12'd1024;

  localparam logic signed [13:0] CentreLo = 14'sd1024;
  localparam logic signed [13:0] CentreHi = 14'sd3072;
  localparam logic signed [13:0] MinLo    = 14'sd1;
  localparam logic signed [13:0] MaxLo    = 14'sd2046;
  localparam logic signed [13:0] MinHi    = 14'sd2049;
  localparam logic signed [13:0] MaxHi    = 14'sd4094;

endpackage

>>> src/rcpp_pulse_calc.sv
// ----------------------------------------------------------------------------
// rcpp_pulse_calc
// works out the 12-bit pulse code of one frame slot
// ----------------------------------------------------------------------------
module rcpp_pulse_calc (
  input  rcpp_pkg::item_t     item_i,
  input  logic [1:0]          fs_mode_i,
  input  logic [4:0]          active_chs_i,
  output logic [11:0]         pulse_o
);
  import rcpp_pkg::*;

  logic               upper;
  logic               live_en;
  logic signed [11:0] src_val;
  logic signed [12:0] sum;
  logic               neg;
  logic [11:0]        mag;
  logic [32:0]        prod;
  logic [11:0]        quo;
  logic signed [13:0] scaled;
  logic signed [13:0] centred;
  logic signed [13:0] lo_lim;
  logic signed [13:0] hi_lim;
  logic [11:0]        scaled_code;
  logic [11:0]        hold_code;
  logic [11:0]        nopulse_code;

  assign upper   = {1'b0, item_i.slot} < item_i.upper_count;
  assign live_en = upper || ({2'b00, item_i.slot} < active_chs_i);

  assign src_val = item_i.send_failsafe ? item_i.failsafe_value : item_i.channel_value;
  assign sum     = 13'(src_val) + 13'(item_i.center_offset);

  // scale on the magnitude so the quotient truncates toward zero
  assign neg  = sum[12];
  assign mag  = neg ? 12'(-sum) : 12'(sum);
  assign prod = 33'(mag) * 33'(RecipK);
  assign quo  = prod[32:RecipShift];

  assign scaled  = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign centred = scaled + (upper ? CentreHi : CentreLo);
  assign lo_lim  = upper ? MinHi : MinLo;
  assign hi_lim  = upper ? MaxHi : MaxLo;

  always_comb begin
    if (centred < lo_lim) begin
      scaled_code = 12'(lo_lim);
    end else if (centred > hi_lim) begin
      scaled_code = 12'(hi_lim);
    end else begin
      scaled_code = 12'(centred);
    end
  end

  assign hold_code    = upper ? CodeHoldHi : CodeHoldLo;
  assign nopulse_code = upper ? CodeNoPulseHi : CodeNoPulseLo;

  always_comb begin
    if (item_i.send_failsafe) begin
      case (fs_mode_e'(fs_mode_i))
        FS_MODE_HOLD:    pulse_o = hold_code;
        FS_MODE_NOPULSE: pulse_o = nopulse_code;
        default: begin
          // custom mode or the unused mode code, the per-channel kind decides
          case (fs_kind_e'(item_i.failsafe_kind))
            FS_KIND_HOLD:    pulse_o = hold_code;
            FS_KIND_NOPULSE: pulse_o = nopulse_code;
            default:         pulse_o = scaled_code;
          endcase
        end
      endcase
    end else begin
      pulse_o = live_en ? scaled_code : CodeNeutral;
    end
  end

endmodule

>>> src/rcpp_byte_out.sv
// ----------------------------------------------------------------------------
// rcpp_byte_out
// holds one packed code pair and sends it as three bytes
// ----------------------------------------------------------------------------
module rcpp_byte_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  rcpp_pkg::pair_t pair_i,
  output logic            free_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte[7:0]
  output logic            m_axis_tlast
);
  import rcpp_pkg::*;

  logic      valid_q;
  byte_sel_e sel_q, sel_d;
  pair_t     pair_q;

  assign free_o = !valid_q || (m_axis_tready && (sel_q == SEL_HI));

  always_comb begin
    case (sel_q)
      SEL_LO:  sel_d = SEL_MID;
      SEL_MID: sel_d = SEL_HI;
      default: sel_d = SEL_LO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= SEL_LO;
    end else if (load_i) begin
      valid_q <= 1'b1;
      sel_q   <= SEL_LO;
    end else if (valid_q && m_axis_tready) begin
      if (sel_q == SEL_HI) begin
        valid_q <= 1'b0;
      end
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pair_q <= pair_i;
    end
  end

  always_comb begin
    case (sel_q)
      SEL_LO:  m_axis_tdata = pair_q.held[7:0];
      SEL_MID: m_axis_tdata = {pair_q.pulse[3:0], pair_q.held[11:8]};
      default: m_axis_tdata = pair_q.pulse[11:4];
    endcase
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = valid_q && (sel_q == SEL_HI);

endmodule

>>> src/rc_channel_pulse_packer.sv
// ----------------------------------------------------------------------------
// rc_channel_pulse_packer
// turns frame slot channel values into packed 12-bit pulse code bytes
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one slot word per cycle, slots 0..7 of a frame in order.
//   each word lands in an input register; the pulse code is computed from
//   that register in one pass (one 12x21 multiply for the 512/682 scale).
//   an even slot only stores its code, in the cycle it leaves the register.
//   an odd slot loads the held code and its own code into the byte register,
//   which sends three bytes on m_axis, tlast on the third.
//   the first byte leaves the byte register once an odd word has passed
//   the input register and been loaded into it. even slots are taken at
//   one word per cycle; an odd slot occupies the byte register for its
//   three bytes, and the next odd slot may load as the third is taken.
//   when m_axis stalls, the byte register holds, an odd word waits in the
//   input register, and s_axis_tready drops until the pair register frees.
//   cfg writes are taken in any cycle (index 0 failsafe mode, 1 active count).
//   reset: mode custom, active count 8, held code 0, both registers empty.
// ----------------------------------------------------------------------------
`include "rc_channel_pulse_packer_macros.svh"

module rc_channel_pulse_packer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // slot[2:0], send_failsafe[3], upper_count[7:4], channel_value[19:8],
  // center_offset[30:20], failsafe_value[42:31], failsafe_kind[44:43]
  input  logic [47:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // out_byte[7:0]
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rcpp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [4:0]                   cfg_data_i
);
  import rcpp_pkg::*;

  logic        s1_valid_q;
  item_t       s1_q;
  item_t       in_item;
  logic        s1_odd;
  logic        s1_fire;
  logic        out_free;
  logic [11:0] pulse;
  logic [11:0] held_pulse_q;
  logic [1:0]  fs_mode_q;
  logic [4:0]  active_chs_q;
  pair_t       pair;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_mode_q    <= FS_MODE_CUSTOM;
      active_chs_q <= 5'd8;
    end else if (cfg_valid_i && (cfg_index_i[CfgIdxW-1:1] == '0)) begin
      case (cfg_reg_e'(cfg_index_i[0]))
        CFG_FS_MODE: fs_mode_q    <= cfg_data_i[1:0];
        default:     active_chs_q <= cfg_data_i;
      endcase
    end
  end

  // input word unpack
  assign in_item.slot           = s_axis_tdata[2:0];
  assign in_item.send_failsafe  = s_axis_tdata[3];
  assign in_item.upper_count    = s_axis_tdata[7:4];
  assign in_item.channel_value  = s_axis_tdata[19:8];
  assign in_item.center_offset  = s_axis_tdata[30:20];
  assign in_item.failsafe_value = s_axis_tdata[42:31];
  assign in_item.failsafe_kind  = s_axis_tdata[44:43];

  assign s1_odd        = s1_q.slot[0];
  assign s1_fire       = s1_valid_q && (!s1_odd || out_free);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_q <= in_item;
    end
  end

  rcpp_pulse_calc u_calc (
    .item_i       (s1_q),
    .fs_mode_i    (fs_mode_q),
    .active_chs_i (active_chs_q),
    .pulse_o      (pulse)
  );

  // even slots park their code for the next odd slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_pulse_q <= '0;
    end else if (s1_fire && !s1_odd) begin
      held_pulse_q <= pulse;
    end
  end

  assign pair.held  = held_pulse_q;
  assign pair.pulse = pulse;

  rcpp_byte_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s1_fire && s1_odd),
    .pair_i        (pair),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `RCPP_ASSERT_NEXT(a_pair_starts_lo, s1_fire && s1_odd, m_axis_tvalid && !m_axis_tlast, "odd slot did not start a byte triple")
  `RCPP_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_fire, s1_valid_q && $stable(s1_q), "blocked slot word lost")
  `RCPP_ASSERT_NEXT(a_held_update, s1_fire && !s1_odd, held_pulse_q == $past(pulse), "even slot code not held")

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the pulse packer byte stream against a cycle-free model of the codes
// ----------------------------------------------------------------------------
// slot words go in from a queue through a clocked driver; every accepted odd
// slot predicts three bytes, which a clocked monitor checks in order. the run
// starts with hand-picked words, then random frames under several failsafe
// and active-count settings, with both sides idling at random and one long
// receiver stall that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import rcpp_pkg::*;

  localparam logic [1:0]  FS_MODE_SPARE = 2'd3;  // unused mode, acts as custom
  localparam logic [1:0]  FS_KIND_SPARE = 2'd3;  // unused kind, acts as value
  localparam logic [11:0] HOLD_LOWER    = 12'd2047;
  localparam logic [11:0] HOLD_UPPER    = 12'd4095;
  localparam logic [11:0] MUTE_LOWER    = 12'd0;
  localparam logic [11:0] MUTE_UPPER    = 12'd2048;
  localparam logic [11:0] NEUTRAL_CODE  = 12'd1024;
  localparam int          SETTLE_CYC    = 10;
  localparam int          STALL_CYC     = 300;
  localparam int          GROUP_WORDS   = 38;

  typedef struct {
    logic [2:0]         slot;
    logic               fs;
    logic [3:0]         upper_count;
    logic signed [11:0] chan_val;
    logic signed [10:0] centre;
    logic signed [11:0] fs_val;
    logic [1:0]         fs_kind;
  } slot_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [4:0]          cfg_data_i = '0;

  slot_word_t  word_q[$];
  frame_byte_t byte_q[$];

  logic [1:0]  mode_q = FS_MODE_CUSTOM;
  logic [4:0]  active_q = 5'd8;
  logic [11:0] held_code = '0;

  int tx_idle_pct = 20;
  int rx_idle_pct = 79;
  bit stall_go = 1'b0;
  bit stall_done = 1'b0;
  int stall_left = 0;

  int err_cnt = 0;
  int n_words = 0;
  int n_fs_words = 0;
  int n_upper_words = 0;
  int n_bytes = 0;

  frame_byte_t got_b;
  frame_byte_t exp_b;

  rc_channel_pulse_packer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [47:0] pack_word(input slot_word_t w);
    return {3'b000, w.fs_kind, w.fs_val, w.centre, w.chan_val, w.upper_count, w.fs, w.slot};
  endfunction

  // scale by 512/682 truncating toward zero, then clamp to the bank window
  function automatic logic [11:0] scale_code(input int sum, input bit upper);
    int v;
    v = (sum * 512) / 682;
    if (upper) begin
      v += 3072;
      if (v < 2049) v = 2049;
      if (v > 4094) v = 4094;
    end else begin
      v += 1024;
      if (v < 1) v = 1;
      if (v > 2046) v = 2046;
    end
    return v[11:0];
  endfunction

  function automatic logic [11:0] pulse_code(input slot_word_t w);
    bit upper;
    upper = int'(w.slot) < int'(w.upper_count);
    if (w.fs) begin
      if (mode_q == FS_MODE_HOLD) return upper ? HOLD_UPPER : HOLD_LOWER;
      if (mode_q == FS_MODE_NOPULSE) return upper ? MUTE_UPPER : MUTE_LOWER;
      if (w.fs_kind == FS_KIND_HOLD) return upper ? HOLD_UPPER : HOLD_LOWER;
      if (w.fs_kind == FS_KIND_NOPULSE) return upper ? MUTE_UPPER : MUTE_LOWER;
      return scale_code(int'(w.fs_val) + int'(w.centre), upper);
    end
    if (upper || int'(w.slot) < int'(active_q))
      return scale_code(int'(w.chan_val) + int'(w.centre), upper);
    return NEUTRAL_CODE;
  endfunction

  task automatic take_word(input slot_word_t w);
    logic [11:0] code;
    code = pulse_code(w);
    n_words++;
    if (w.fs) n_fs_words++;
    if (int'(w.slot) < int'(w.upper_count)) n_upper_words++;
    if (!w.slot[0]) begin
      held_code = code;
    end else begin
      byte_q.push_back('{data: held_code[7:0], last: 1'b0});
      byte_q.push_back('{data: {code[3:0], held_code[11:8]}, last: 1'b0});
      byte_q.push_back('{data: code[11:4], last: 1'b1});
    end
  endtask

  // slot word driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_word(word_q[0]);
        void'(word_q.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered word
      end else if (word_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_word(word_q[0]);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // byte receiver, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_go && !stall_done) begin
      stall_done = 1'b1;
      stall_left = STALL_CYC;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  // byte monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_b = '{data: m_axis_tdata, last: m_axis_tlast};
      n_bytes++;
      if (byte_q.size() == 0) begin
        $display("%0t: unexpected word data=%02h last=%0b", $time, got_b.data, got_b.last);
        err_cnt++;
      end else begin
        exp_b = byte_q.pop_front();
        if (got_b.data !== exp_b.data) begin
          $display("%0t: data mismatch expected=%02h actual=%02h", $time, exp_b.data,
                   got_b.data);
          err_cnt++;
        end
        if (got_b.last !== exp_b.last) begin
          $display("%0t: last mismatch expected=%0b actual=%0b", $time, exp_b.last,
                   got_b.last);
          err_cnt++;
        end
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk_i); while (word_q.size() != 0 || byte_q.size() != 0);
    // an even slot may still be landing in the held code
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [4:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgIdxW'(idx);
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_FS_MODE) mode_q = val[1:0];
    else active_q = val;
  endtask

  task automatic set_phase(input logic [1:0] mode, input logic [4:0] active,
                           input int tx_pct, input int rx_pct);
    wait_idle();
    write_reg(CFG_FS_MODE, {3'b000, mode});
    write_reg(CFG_ACTIVE_CHS, active);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  task automatic push_word(input int slot, input bit fs, input int uc, input int cv,
                           input int co, input int fv, input logic [1:0] kind);
    slot_word_t w;
    w.slot        = slot[2:0];
    w.fs          = fs;
    w.upper_count = uc[3:0];
    w.chan_val    = cv[11:0];
    w.centre      = co[10:0];
    w.fs_val      = fv[11:0];
    w.fs_kind     = kind;
    word_q.push_back(w);
  endtask

  // extremes and small values weighted up against the full range
  function automatic int pick_signed(input int bits);
    int half;
    half = 1 << (bits - 1);
    case ($urandom_range(0, 9))
      0: return -half;
      1: return half - 1;
      2: return int'($urandom_range(0, 40)) - 20;
      default: return int'($urandom_range(0, 2 * half - 1)) - half;
    endcase
  endfunction

  task automatic push_random(input int slot, input bit fs, input int uc);
    push_word(slot, fs, uc, pick_signed(12), pick_signed(11), pick_signed(12),
              2'($urandom_range(0, 3)));
  endtask

  // mostly whole frames in slot order, some stray words in between
  task automatic push_frames(input int count);
    int n;
    bit fs;
    int uc;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 15) begin
        push_random($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 15));
        n++;
      end else begin
        fs = $urandom_range(0, 99) < 35;
        uc = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
        for (int s = 0; s < 8; s++) push_random(s, fs, uc);
        n += 8;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_phase(FS_MODE_CUSTOM, 5'd8, 20, 79);
    // odd slot straight after reset pairs with a zero held code
    push_word(1, 0, 0, 100, 0, 0, FS_KIND_VALUE);
    push_word(0, 0, 0, 2047, 1023, 0, FS_KIND_VALUE);
    push_word(1, 0, 0, -2048, -1024, 0, FS_KIND_VALUE);
    push_word(2, 0, 0, 0, 0, 0, FS_KIND_VALUE);
    push_word(3, 0, 0, 682, 0, 0, FS_KIND_VALUE);
    // truncation toward zero on small negatives
    push_word(4, 0, 0, -1, 0, 0, FS_KIND_VALUE);
    push_word(5, 0, 0, -2, 0, 0, FS_KIND_VALUE);
    push_word(6, 0, 8, 2047, 1023, 0, FS_KIND_VALUE);
    push_word(7, 0, 8, -2048, -1024, 0, FS_KIND_VALUE);
    push_word(0, 1, 0, 0, 1023, 2047, FS_KIND_VALUE);
    push_word(1, 1, 0, 0, -1024, -2048, FS_KIND_VALUE);
    push_word(2, 1, 0, 0, 0, 0, FS_KIND_HOLD);
    push_word(3, 1, 0, 0, 0, 0, FS_KIND_NOPULSE);
    push_word(4, 1, 0, 0, 0, 341, FS_KIND_SPARE);
    push_word(5, 1, 15, 0, 0, 0, FS_KIND_HOLD);
    push_word(6, 1, 15, 0, 0, 0, FS_KIND_NOPULSE);
    push_word(7, 1, 15, 0, -1, 0, FS_KIND_VALUE);
    push_word(0, 0, 9, -1000, 0, 0, FS_KIND_VALUE);
    push_word(1, 0, 9, 1000, 0, 0, FS_KIND_VALUE);
    // out of order slots still pair with whatever is held
    push_word(6, 0, 0, 5, 0, 0, FS_KIND_VALUE);
    push_word(3, 0, 0, 5, 0, 0, FS_KIND_VALUE);
    push_word(2, 0, 0, -682, 0, 0, FS_KIND_VALUE);
    push_word(5, 0, 0, 0, 1023, 0, FS_KIND_VALUE);

    set_phase(FS_MODE_HOLD, 5'd0, 20, 79);
    push_frames(GROUP_WORDS);
    set_phase(FS_MODE_NOPULSE, 5'd16, 79, 20);
    push_frames(GROUP_WORDS);
    set_phase(FS_MODE_SPARE, 5'd31, 79, 20);
    push_frames(GROUP_WORDS);
    set_phase(FS_MODE_CUSTOM, 5'd3, 0, 0);
    push_frames(GROUP_WORDS);
    stall_go = 1'b1;
    set_phase(FS_MODE_CUSTOM, 5'd5, 0, 0);
    push_frames(GROUP_WORDS);

    wait_idle();
    $display("covered %0d slot words (%0d failsafe, %0d upper bank), %0d bytes checked",
             n_words, n_fs_words, n_upper_words, n_bytes);
    $display("settings: all failsafe modes, active counts 0 to 31, long output stall");
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d words and %0d bytes outstanding", word_q.size(), byte_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
